[rtl/lzss_pkg.sv]
// ----------------------------------------------------------------------------
// lzss_pkg
// shared constants and types for the lzss stream decompressor
// ----------------------------------------------------------------------------
package lzss_pkg;

	localparam int HistoryDepth = 4096;
	localparam int OutLanes     = 8;

	localparam logic [7:0] Magic0 = 8'h52;
	localparam logic [7:0] Magic1 = 8'h55;
	localparam logic [7:0] Magic2 = 8'h58;

	localparam logic [15:0] FlagTop   = 16'h8000;
	localparam logic [15:0] NibMask   = 16'hF000;
	localparam logic [15:0] DistMask  = 16'h0FFF;
	localparam logic [8:0]  ExtraBase = 9'h10;

	typedef enum logic [6:0] {
		PH_HDR     = 7'b0000001,
		PH_FLAG_LO = 7'b0000010,
		PH_FLAG_HI = 7'b0000100,
		PH_ELEM    = 7'b0001000,
		PH_TOK_HI  = 7'b0010000,
		PH_EXTRA   = 7'b0100000,
		PH_DONE    = 7'b1000000
	} phase_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_COPY  = 5'b00010,
		ST_RDW   = 5'b00100,
		ST_FLUSH = 5'b01000,
		ST_OUT   = 5'b10000
	} seq_t;

endpackage

[rtl/lzss_stream_decompressor_top.sv]
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_top
// lzss decompressor, 4 KiB history, byte-serial input, packed byte output
// ----------------------------------------------------------------------------
// input channel: one compressed byte per item with in_last marking the end of
// a stream; after in_last the block rearms for the next header.
// output channel: up to OUT_LANES bytes per item, earliest byte lowest, with
// byte_count, run_last on the final item for an input item, size_reached,
// stream_end and bad_magic.
// a header, flag or token byte that produces no result keeps the block idle
// unless in_last is set. any item that produces output holds in_ready low
// until its last result is taken; a literal passes accept, flush and hand-out.
// a match copies each byte through the history ram with a read in ST_COPY
// and a write in ST_RDW, and each result of a match goes through a lane
// check in ST_COPY, a flush and a hand-out.
// reset clears all parse state; the history ram is not cleared, because a
// byte not yet written in the current stream is read as zero by a match.
// when the receiver stalls the result register holds and no input is taken.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_top
	import lzss_pkg::*;
#(
	parameter int OUT_LANES = OutLanes
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	input  logic                   in_last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_LANES*8-1:0] out_bytes,
	output logic [3:0]             byte_count,
	output logic                   run_last,
	output logic                   size_reached,
	output logic                   stream_end,
	output logic                   bad_magic
);

	localparam int AW = $clog2(HistoryDepth);
	localparam int LW = $clog2(OUT_LANES + 1);

	seq_t                   st_q;
	phase_t                 ph_q;
	logic [2:0]             hidx_q;
	logic                   big_q;
	logic [31:0]            dsize_q;
	logic [15:0]            flag_q;
	logic [3:0]             fused_q;
	logic [7:0]             tlo_q;
	logic [15:0]            tok_q;
	logic [31:0]            prod_q;
	logic [AW-1:0]          wptr_q;
	logic                   mfail_q;
	logic [7:0]             hist [HistoryDepth];
	logic [7:0]             rd_q;
	logic [8:0]             len_q;
	logic [16:0]            dist_q;
	logic [OUT_LANES*8-1:0] acc_q;
	logic [LW-1:0]          fill_q;
	logic                   last_q;
	logic                   any_q;
	logic                   pend_adv_q;
	logic [7:0]             wbyte;
	logic                   we;
	logic                   reached;
	logic                   hit_size;

	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign hit_size = (prod_q >= dsize_q);
	assign reached = (ph_q != PH_HDR) && !mfail_q && hit_size;

	always_ff @(posedge clk) begin
		if (we) hist[wptr_q] <= wbyte;
		rd_q <= hist[wptr_q - dist_q[AW-1:0]];
	end

	// byte going into history and lanes this cycle
	always_comb begin
		we = 1'b0;
		wbyte = in_byte;
		if (st_q == ST_IDLE && in_valid && ph_q == PH_ELEM && !flag_q[15]) we = 1'b1;
		if (st_q == ST_RDW) begin
			we = 1'b1;
			wbyte = ({15'd0, dist_q} <= prod_q) ? rd_q : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; ph_q <= PH_HDR; hidx_q <= '0; big_q <= 1'b0;
			dsize_q <= '0; flag_q <= '0; fused_q <= '0; tlo_q <= '0; tok_q <= '0;
			prod_q <= '0; wptr_q <= '0; mfail_q <= 1'b0; len_q <= '0; dist_q <= '0;
			acc_q <= '0; fill_q <= '0; last_q <= 1'b0; any_q <= 1'b0;
			pend_adv_q <= 1'b0;
			out_bytes <= '0; byte_count <= '0; run_last <= 1'b0;
			size_reached <= 1'b0; stream_end <= 1'b0; bad_magic <= 1'b0;
		end else begin
			if (we) begin
				wptr_q <= wptr_q + 1'b1;
				prod_q <= prod_q + 1'b1;
				acc_q[fill_q[$clog2(OUT_LANES > 1 ? OUT_LANES : 2)-1:0]*8 +: 8] <= wbyte;
				fill_q <= fill_q + 1'b1;
			end
			case (st_q)
				ST_IDLE: if (in_valid) begin
					last_q <= in_last;
					any_q <= 1'b0;
					pend_adv_q <= 1'b0;
					st_q <= in_last ? ST_FLUSH : ST_IDLE;
					case (ph_q)
						PH_HDR: begin
							if (hidx_q < 3'd3 && in_byte != (hidx_q == 3'd0 ? Magic0 :
									hidx_q == 3'd1 ? Magic1 : Magic2)) begin
								mfail_q <= 1'b1;
								ph_q <= PH_DONE;
								st_q <= ST_FLUSH;
							end else begin
								if (hidx_q == 3'd3) big_q <= (in_byte != 8'd0);
								else if (hidx_q >= 3'd4) begin
									if (big_q) dsize_q <= {dsize_q[23:0], in_byte};
									else dsize_q[{hidx_q[1:0], 3'b000} +: 8] <= in_byte;
								end
								if (hidx_q == 3'd7) begin
									if (big_q) ph_q <= ({dsize_q[23:0], in_byte} == 32'd0) ?
										PH_DONE : PH_FLAG_LO;
									else ph_q <= ((dsize_q | ({24'd0, in_byte} << 24)) == 32'd0) ?
										PH_DONE : PH_FLAG_LO;
								end else hidx_q <= hidx_q + 1'b1;
							end
						end
						PH_FLAG_LO: begin flag_q <= {8'd0, in_byte}; ph_q <= PH_FLAG_HI; end
						PH_FLAG_HI: begin
							flag_q[15:8] <= in_byte; fused_q <= '0; ph_q <= PH_ELEM;
						end
						PH_ELEM: begin
							if ((flag_q & FlagTop) == 16'd0) begin
								pend_adv_q <= 1'b1;
								st_q <= ST_FLUSH;
							end else begin
								tlo_q <= in_byte; ph_q <= PH_TOK_HI;
							end
						end
						PH_TOK_HI: begin
							tok_q <= {in_byte, tlo_q};
							if (({in_byte, tlo_q} & NibMask) != 16'd0) begin
								len_q <= {5'd0, in_byte[7:4]} + 9'd1;
								dist_q <= 17'({in_byte, tlo_q} & DistMask) + 17'd1;
								st_q <= ST_COPY;
							end else ph_q <= PH_EXTRA;
						end
						PH_EXTRA: begin
							len_q <= {1'b0, in_byte} + ExtraBase + 9'd1;
							dist_q <= {1'b0, tok_q} + 17'd1;
							st_q <= ST_COPY;
						end
						default: ;
					endcase
				end
				// the read address is presented in this state; the read data is written in ST_RDW
				ST_COPY: begin
					if (len_q == 9'd0 || hit_size) begin
						pend_adv_q <= 1'b1;
						st_q <= ST_FLUSH;
					end else if (fill_q == LW'(OUT_LANES)) st_q <= ST_FLUSH;
					else st_q <= ST_RDW;
				end
				ST_RDW: begin
					len_q <= len_q - 1'b1;
					st_q <= ST_COPY;
				end
				ST_FLUSH: begin
					if (pend_adv_q) begin
						pend_adv_q <= 1'b0;
						flag_q <= {flag_q[14:0], 1'b0};
						fused_q <= fused_q + 1'b1;
						if (hit_size) ph_q <= PH_DONE;
						else ph_q <= (fused_q == 4'd15) ? PH_FLAG_LO : PH_ELEM;
					end
					if (fill_q != '0 || (!any_q && (last_q || mfail_q))) begin
						out_bytes <= acc_q;
						byte_count <= 4'(fill_q);
						size_reached <= reached;
						stream_end <= last_q;
						bad_magic <= mfail_q;
						run_last <= !(len_q != 9'd0 && !hit_size && fill_q == LW'(OUT_LANES));
						acc_q <= '0;
						fill_q <= '0;
						any_q <= 1'b1;
						st_q <= ST_OUT;
					end else st_q <= ST_IDLE;
				end
				ST_OUT: if (out_ready) begin
					if (!run_last) st_q <= ST_COPY;
					else begin
						st_q <= ST_IDLE;
						if (last_q) begin
							ph_q <= PH_HDR; hidx_q <= '0; big_q <= 1'b0; dsize_q <= '0;
							flag_q <= '0; fused_q <= '0; tlo_q <= '0; tok_q <= '0;
							prod_q <= '0; wptr_q <= '0; mfail_q <= 1'b0; len_q <= '0;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bytes))
		else $error("result changed while stalled");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count <= 4'(OUT_LANES))
		else $error("byte count over lanes");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(OUT_LANES))
		else $error("lane fill overflow");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the lzss stream decompressor: directed header,
// literal and match streams, then random well-formed and broken streams,
// with every result checked against a bit-level predictor
// ----------------------------------------------------------------------------
module tb;
	import lzss_pkg::*;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        last_of_item;
		logic        reached;
		logic        at_end;
		logic        bad;
	} lz_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        in_last;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        run_last;
	logic        size_reached;
	logic        stream_end;
	logic        bad_magic;

	lzss_stream_decompressor_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
		.out_valid(out_valid), .out_ready(out_ready), .out_bytes(out_bytes),
		.byte_count(byte_count), .run_last(run_last), .size_reached(size_reached),
		.stream_end(stream_end), .bad_magic(bad_magic)
	);

	localparam int IdleLimit = 20000;

	// predictor state
	phase_t      ph;
	int unsigned hdr_idx;
	bit          big_end;
	logic [31:0] decl_size;
	logic [15:0] flags;
	logic [3:0]  flags_used;
	logic [7:0]  tok_lo;
	logic [15:0] tok;
	logic [31:0] produced;
	logic [7:0]  history [HistoryDepth];
	logic [11:0] wr_ptr;
	bit          magic_bad;

	logic [63:0] acc;
	int unsigned fill;
	bit          cur_last;

	lz_result_t  expected_q[$];
	int          errors;
	int          idle_cycles;
	bit          quiet_out;
	bit          quiet_in;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic void clear_parse();
		ph = PH_HDR;
		hdr_idx = 0;
		big_end = 0;
		decl_size = '0;
		flags = '0;
		flags_used = '0;
		tok_lo = '0;
		tok = '0;
		produced = '0;
		wr_ptr = '0;
		magic_bad = 0;
	endfunction

	function automatic void push_result();
		lz_result_t r;
		r.data = acc;
		r.cnt = fill[3:0];
		r.last_of_item = 1'b0;
		r.reached = (ph != PH_HDR) && !magic_bad && (produced >= decl_size);
		r.at_end = cur_last;
		r.bad = magic_bad;
		expected_q.push_back(r);
		acc = '0;
		fill = 0;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		history[wr_ptr] = b;
		wr_ptr++;
		produced++;
		acc |= 64'(b) << (8 * fill);
		fill++;
		if (fill >= OutLanes)
			push_result();
	endfunction

	function automatic void copy_back(input int unsigned len, input int unsigned distance);
		logic [7:0] b;
		for (int unsigned k = 0; k < len; k++) begin
			if (produced >= decl_size)
				break;
			b = (distance <= produced) ? history[wr_ptr - 12'(distance)] : 8'h00;
			put_byte(b);
		end
	endfunction

	function automatic void next_flag();
		flags = flags << 1;
		flags_used++;
		if (produced >= decl_size)
			ph = PH_DONE;
		else
			ph = (flags_used == 0) ? PH_FLAG_LO : PH_ELEM;
	endfunction

	// computes the results of one compressed byte and queues them
	function automatic void decode_byte(input logic [7:0] b, input logic last);
		int  n_before;
		bit  bad_now;
		logic [7:0] magic_b;
		n_before = expected_q.size();
		bad_now = 0;
		acc = '0;
		fill = 0;
		cur_last = last;
		case (ph)
			PH_HDR: begin
				magic_b = (hdr_idx == 0) ? Magic0 : (hdr_idx == 1) ? Magic1 : Magic2;
				if (hdr_idx < 3 && b != magic_b) begin
					magic_bad = 1;
					ph = PH_DONE;
					bad_now = 1;
				end else begin
					if (hdr_idx == 3)
						big_end = (b != 0);
					else if (hdr_idx >= 4) begin
						if (big_end)
							decl_size = (decl_size << 8) | 32'(b);
						else
							decl_size |= 32'(b) << (8 * (hdr_idx - 4));
					end
					if (hdr_idx == 7)
						ph = (decl_size == 0) ? PH_DONE : PH_FLAG_LO;
					else
						hdr_idx++;
				end
			end
			PH_FLAG_LO: begin
				flags = {8'h00, b};
				ph = PH_FLAG_HI;
			end
			PH_FLAG_HI: begin
				flags[15:8] = b;
				flags_used = '0;
				ph = PH_ELEM;
			end
			PH_ELEM: begin
				if ((flags & FlagTop) == 0) begin
					put_byte(b);
					next_flag();
				end else begin
					tok_lo = b;
					ph = PH_TOK_HI;
				end
			end
			PH_TOK_HI: begin
				tok = {b, tok_lo};
				if ((tok & NibMask) != 0) begin
					copy_back(int'(tok[15:12]) + 1, int'(tok & DistMask) + 1);
					next_flag();
				end else
					ph = PH_EXTRA;
			end
			PH_EXTRA: begin
				copy_back(int'(b) + int'(ExtraBase) + 1, int'(tok) + 1);
				next_flag();
			end
			default: ;
		endcase
		if (fill > 0 || (expected_q.size() == n_before && (bad_now || last)))
			push_result();
		if (expected_q.size() > n_before)
			expected_q[expected_q.size() - 1].last_of_item = 1'b1;
		if (last)
			clear_parse();
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!quiet_in && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_byte(b, last);
		@(negedge clk);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		lz_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0)
				report($sformatf("unexpected result data=%h cnt=%0d", out_bytes, byte_count));
			else begin
				e = expected_q.pop_front();
				if (out_bytes !== e.data)
					report($sformatf("out_bytes %h exp %h", out_bytes, e.data));
				if (byte_count !== e.cnt)
					report($sformatf("byte_count %0d exp %0d", byte_count, e.cnt));
				if (run_last !== e.last_of_item)
					report($sformatf("run_last %b exp %b", run_last, e.last_of_item));
				if (size_reached !== e.reached)
					report($sformatf("size_reached %b exp %b", size_reached, e.reached));
				if (stream_end !== e.at_end)
					report($sformatf("stream_end %b exp %b", stream_end, e.at_end));
				if (bad_magic !== e.bad)
					report($sformatf("bad_magic %b exp %b", bad_magic, e.bad));
			end
		end
	end

	always @(negedge clk)
		out_ready <= quiet_out || ($urandom_range(99) >= 29);

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_header(input logic [31:0] size, input bit be);
		send_byte(Magic0, 0);
		send_byte(Magic1, 0);
		send_byte(Magic2, 0);
		send_byte(be ? 8'h01 : 8'h00, 0);
		for (int i = 0; i < 4; i++)
			send_byte(be ? size[8*(3-i) +: 8] : size[8*i +: 8], 0);
	endtask

	// one group of 16 elements; literals and tokens chosen at random
	task automatic send_group(input int unsigned match_pct, input bit long_dist);
		logic [15:0] f;
		logic [15:0] t;
		f = 16'($urandom);
		for (int i = 0; i < 16; i++)
			f[i] = ($urandom_range(99) < match_pct);
		send_byte(f[7:0], 0);
		send_byte(f[15:8], 0);
		for (int i = 15; i >= 0; i--) begin
			if (!f[i])
				send_byte(8'($urandom), 0);
			else begin
				t = 16'($urandom);
				if (!long_dist)
					t[11:0] = 12'($urandom_range(15));
				if ($urandom_range(3) == 0) begin
					t[15:12] = 4'h0;
					send_byte(t[7:0], 0);
					send_byte(t[15:8], 0);
					send_byte(8'($urandom_range(255) & ($urandom_range(3) == 0 ? 8'hFF : 8'h0F)), 0);
				end else begin
					send_byte(t[7:0], 0);
					send_byte(t[15:8], 0);
				end
			end
		end
	endtask

	task automatic test_header_cases();
		// wrong magic in each position, with in_last on or right after the wrong byte
		send_byte(8'h00, 0);
		send_byte(8'hFF, 1);
		send_byte(Magic0, 0);
		send_byte(8'hAA, 1);
		send_byte(Magic0, 0);
		send_byte(Magic1, 0);
		send_byte(8'h59, 1);
		// zero declared size
		send_header(32'd0, 0);
		send_byte(8'h12, 1);
		// early in_last inside the header
		send_byte(Magic0, 0);
		send_byte(Magic1, 1);
	endtask

	task automatic test_literals_and_matches();
		// big-endian size 5, five literals that reach the size
		send_header(32'd5, 1);
		send_byte(8'h40, 0);
		send_byte(8'h00, 0);
		send_byte(8'hFF, 0);
		send_byte(8'h00, 0);
		send_byte(8'hA5, 0);
		send_byte(8'h00, 0);
		send_byte(8'hF0, 1);
		// match before the stream start reads zeros; extended length maximum
		send_header(32'hFFFF_FFFF, 0);
		send_byte(8'h00, 0);
		send_byte(8'hC0, 0);
		send_byte(8'hFF, 0);
		send_byte(8'hFF, 0);
		send_byte(8'h00, 0);
		send_byte(8'h00, 0);
		send_byte(8'hFF, 0);
		send_byte(8'h7E, 1);
	endtask

	task automatic test_random_streams(input int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			case ($urandom_range(9))
				0: begin
					for (int i = 0; i < 4; i++)
						send_byte(8'($urandom), ($urandom_range(3) == 0));
					sent += 4;
				end
				1: begin
					send_header(32'($urandom_range(1, 40)), $urandom_range(1));
					send_byte(8'($urandom), 0);
					send_byte(8'($urandom), 1);
					sent += 10;
				end
				default: begin
					send_header($urandom_range(7) == 0 ? 32'($urandom) :
						32'($urandom_range(1, 120)), $urandom_range(1));
					for (int g = $urandom_range(1, 3); g > 0; g--) begin
						send_group($urandom_range(10, 70), $urandom_range(3) == 0);
						sent += 24;
					end
					send_byte(8'($urandom), 1);
					sent += 9;
				end
			endcase
		end
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		quiet_out = 0;
		quiet_in = 0;
		in_valid = 1'b0;
		in_byte = '0;
		in_last = 1'b0;
		out_ready = 1'b0;
		clear_parse();
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_header_cases();
		test_literals_and_matches();
		test_random_streams(80);
		quiet_out = 1;
		quiet_in = 1;
		test_random_streams(30);
		quiet_out = 0;
		quiet_in = 0;
		test_random_streams(70);
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
